// File: rtl/dd2dms_pkg.sv
// ----------------------------------------------------------------------------
// dd2dms_pkg
// Shared widths, output modes and constants for the degrees to DMS converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dd2dms_pkg;

    localparam int ANGLE_W     = 33;
    localparam int DEG_W       = 8;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int FRAC_OUT_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_FIELD_W = DEG_W + MIN_W + SEC_W + FRAC_OUT_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MIN_W-1:0] UNIT_WRAP = MIN_W'(60);
    localparam logic [MIN_W-1:0] UNIT_LAST = MIN_W'(59);

    typedef enum logic [1:0] {
        MODE_SEC_FRAC = 2'd0,
        MODE_SEC_RND  = 2'd1,
        MODE_MIN_FRAC = 2'd2,
        MODE_MIN_RND  = 2'd3
    } mode_t;

endpackage

`default_nettype wire

// File: rtl/dd2dms_front.sv
// ----------------------------------------------------------------------------
// dd2dms_front
// Accepts angle beats, takes the sign and magnitude, splits whole degrees
// from the fraction of a degree and registers the result for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dd2dms_front
    import dd2dms_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [ANGLE_W-1:0]                 angle,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [ANGLE_FRAC_BITS+DEG_W:0]          out_data   // neg, deg, frac
);

    localparam int EXT_W = (ANGLE_FRAC_BITS + DEG_W > ANGLE_W) ?
                           ANGLE_FRAC_BITS + DEG_W : ANGLE_W;

    logic                           vld_reg;
    logic                           vld_next;
    logic [ANGLE_FRAC_BITS+DEG_W:0] data_reg;
    logic                           neg;
    logic [ANGLE_W-1:0]             mag;
    logic [EXT_W-1:0]               mag_ext;
    logic                           take;

    assign in_ready = !vld_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign neg      = angle[ANGLE_W-1];
    assign mag      = neg ? (~angle + ANGLE_W'(1)) : angle;
    assign mag_ext  = EXT_W'(mag);
    assign vld_next = take ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= {mag_ext[ANGLE_FRAC_BITS-1:0],
                         mag_ext[ANGLE_FRAC_BITS+DEG_W-1:ANGLE_FRAC_BITS], neg};
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/dd2dms_queue.sv
// ----------------------------------------------------------------------------
// dd2dms_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dd2dms_queue
    import dd2dms_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dd2dms_back.sv
// ----------------------------------------------------------------------------
// dd2dms_back
// Three-stage pipeline: minutes from fraction x 60, seconds from remainder
// x 60, then rounding, carry and mode selection into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dd2dms_back
    import dd2dms_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mode_t                             mode,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ANGLE_FRAC_BITS+DEG_W:0]    in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_hemi,
    output logic [OUT_TDATA_W-1:0]                 out_tdata
);

    localparam int AFB    = ANGLE_FRAC_BITS;
    localparam int PROD_W = AFB + 6;
    localparam int SCL_W  = (AFB > FRACTION_BITS) ? AFB : FRACTION_BITS;
    localparam int SHR    = (AFB >= FRACTION_BITS) ? AFB - FRACTION_BITS : 0;
    localparam int SHL    = (AFB < FRACTION_BITS) ? FRACTION_BITS - AFB : 0;
    localparam int KEEP_W = (FRACTION_BITS < FRAC_OUT_W) ? FRACTION_BITS : FRAC_OUT_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (AFB - 1);

    function automatic logic [PROD_W-1:0] times60(input logic [AFB-1:0] x);
        return {x, 6'b0} - {4'b0, x, 2'b0};
    endfunction

    function automatic logic [FRAC_OUT_W-1:0] scale_frac(input logic [AFB-1:0] rem);
        logic [SCL_W-1:0] tmp;
        tmp = (SCL_W'(rem) >> SHR) << SHL;
        return FRAC_OUT_W'(tmp[KEEP_W-1:0]);
    endfunction

    // stage 1
    logic                s1_vld_reg;
    logic                s1_ready;
    logic                s1_neg_reg;
    logic [DEG_W-1:0]    s1_deg_reg;
    logic [PROD_W-1:0]   s1_m60_reg;

    // stage 2
    logic                s2_vld_reg;
    logic                s2_ready;
    logic                s2_neg_reg;
    logic [DEG_W-1:0]    s2_deg_reg;
    logic [MIN_W-1:0]    s2_min_t_reg;
    logic [MIN_W-1:0]    s2_min_r_reg;
    logic [AFB-1:0]      s2_mrem_reg;
    logic [PROD_W-1:0]   s2_s60_reg;
    logic [PROD_W-1:0]   m_rnd_sum;

    // output stage
    logic                o_vld_reg;
    logic                o_hemi_reg;
    logic [OUT_FIELD_W-1:0] o_data_reg;
    logic [PROD_W-1:0]   s_rnd_sum;
    logic [SEC_W-1:0]    sec_t;
    logic [SEC_W-1:0]    sec_r;
    logic [DEG_W-1:0]    deg_o;
    logic [MIN_W-1:0]    min_o;
    logic [SEC_W-1:0]    sec_o;
    logic [FRAC_OUT_W-1:0] frac_o;

    assign in_ready = !s1_vld_reg || s1_ready;
    assign s1_ready = !s2_vld_reg || s2_ready;
    assign s2_ready = !o_vld_reg || out_ready;

    assign m_rnd_sum = s1_m60_reg + HALF;
    assign s_rnd_sum = s2_s60_reg + HALF;
    assign sec_t     = s2_s60_reg[PROD_W-1:AFB];
    assign sec_r     = s_rnd_sum[PROD_W-1:AFB];

    always_comb
    begin
        deg_o  = s2_deg_reg;
        min_o  = s2_min_t_reg;
        sec_o  = '0;
        frac_o = '0;
        unique case (mode)
            MODE_SEC_FRAC:
            begin
                sec_o  = sec_t;
                frac_o = scale_frac(s2_s60_reg[AFB-1:0]);
            end
            MODE_SEC_RND:
            begin
                sec_o = sec_r;
                if (sec_r == UNIT_WRAP)
                begin
                    sec_o = '0;
                    if (s2_min_t_reg == UNIT_LAST)
                    begin
                        min_o = '0;
                        deg_o = s2_deg_reg + DEG_W'(1);
                    end
                    else
                    begin
                        min_o = s2_min_t_reg + MIN_W'(1);
                    end
                end
            end
            MODE_MIN_FRAC:
            begin
                frac_o = scale_frac(s2_mrem_reg);
            end
            MODE_MIN_RND:
            begin
                min_o = s2_min_r_reg;
                if (s2_min_r_reg == UNIT_WRAP)
                begin
                    min_o = '0;
                    deg_o = s2_deg_reg + DEG_W'(1);
                end
            end
            default:
            begin
                deg_o = s2_deg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s2_ready)
            begin
                o_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_neg_reg <= in_data[0];
            s1_deg_reg <= in_data[DEG_W:1];
            s1_m60_reg <= times60(in_data[AFB+DEG_W:DEG_W+1]);
        end
        if (s1_ready && s1_vld_reg)
        begin
            s2_neg_reg   <= s1_neg_reg;
            s2_deg_reg   <= s1_deg_reg;
            s2_min_t_reg <= s1_m60_reg[PROD_W-1:AFB];
            s2_min_r_reg <= m_rnd_sum[PROD_W-1:AFB];
            s2_mrem_reg  <= s1_m60_reg[AFB-1:0];
            s2_s60_reg   <= times60(s1_m60_reg[AFB-1:0]);
        end
        if (s2_ready && s2_vld_reg)
        begin
            o_hemi_reg <= s2_neg_reg;
            o_data_reg <= {frac_o, sec_o, min_o, deg_o};
        end
    end

    assign out_valid = o_vld_reg;
    assign out_hemi  = o_hemi_reg;
    assign out_tdata = OUT_TDATA_W'(o_data_reg);

endmodule

`default_nettype wire

// File: rtl/decimal_degrees_to_dms.sv
// ----------------------------------------------------------------------------
// decimal_degrees_to_dms
// Signed fixed-point degrees to hemisphere, degrees, minutes and seconds.
// ----------------------------------------------------------------------------
// Takes one angle beat per clock and gives one result beat per clock while the
// output side is ready; a result passes through the front register, the queue,
// two back stages and the output register after its beat is accepted. Every
// stage handles one item per cycle unless held by back-pressure: both
// multiplications by 60 are shift-and-subtract, each in a stage of its own.
// output_mode is written on the cfg channel, which is always ready; write it
// only when no beat is in flight. The kind flag selects N/S or E/W naming only
// and does not change the result.
`default_nettype none

module decimal_degrees_to_dms
    import dd2dms_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // angle[32:0], zero pad
    input  wire logic [0:0]             s_axis_tuser,   // kind
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // degrees, minutes, seconds,
                                                        // fraction, zero pad
    output logic [0:0]                  m_axis_tuser,   // hemisphere
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_data        // output_mode
);

    localparam int QW = ANGLE_FRAC_BITS + DEG_W + 1;

    mode_t          mode_reg;
    mode_t          mode_next;
    logic           f_valid;
    logic           f_ready;
    logic [QW-1:0]  f_data;
    logic           q_valid;
    logic           q_ready;
    logic [QW-1:0]  q_data;
    logic           kind_unused;

    assign cfg_ready   = 1'b1;
    assign mode_next   = (cfg_valid && cfg_ready) ? mode_t'(cfg_data) : mode_reg;
    assign kind_unused = s_axis_tuser[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEC_FRAC;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    dd2dms_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .angle     (s_axis_tdata[ANGLE_W-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    dd2dms_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    dd2dms_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hemi  (m_axis_tuser[0]),
        .out_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/dd2dms_checker.sv
// ----------------------------------------------------------------------------
// dd2dms_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dd2dms_checker
    import dd2dms_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]             m_axis_tuser,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [1:0]             cfg_data
);

    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic [1:0] mode_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
        begin
            pend_next = pend_reg + 4'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pend_next = pend_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            mode_reg <= MODE_SEC_FRAC;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != 4'd0)
        else $error("result beat without an accepted angle");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:8] < UNIT_WRAP &&
                          m_axis_tdata[19:14] < UNIT_WRAP &&
                          m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0)
        else $error("minutes or seconds out of range, or pad bits set");

    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((mode_reg != MODE_MIN_FRAC && mode_reg != MODE_MIN_RND) ||
             m_axis_tdata[19:14] == '0) &&
            ((mode_reg != MODE_SEC_RND && mode_reg != MODE_MIN_RND) ||
             m_axis_tdata[35:20] == '0))
        else $error("unused field not zero for the current mode");

endmodule

bind decimal_degrees_to_dms dd2dms_checker u_dd2dms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);

`default_nettype wire
